// ----- src/nnis_pkg.sv -----
// Package for the nearest neighbor image scaler: item types, codes, constants, reciprocal table.
package nnis_pkg;

    localparam int MAX_ROWS_DEF        = 256;
    localparam int MAX_COLS_DEF        = 256;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // Mark-mode division by multiplication with a reciprocal of RECIP_SHIFT fraction bits.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 19;

    localparam int COORD_W  = 12;
    localparam int PIX_W    = 8;
    localparam int INV_W    = 22;
    localparam int FACT_W   = 5;
    localparam int SIZE_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 22;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_op;

    typedef enum logic {
        MODE_SCALE = 1'b0,
        MODE_MARK  = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_INV_SCALE  = 3'd1,
        CFG_INT_FACTOR = 3'd2,
        CFG_SRC_ROWS   = 3'd3,
        CFG_SRC_COLS   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             inserted;
    } t_out_item;

    // ceil(2^RECIP_SHIFT / f); factor zero uses the entry for one.
    localparam logic [RECIP_W-1:0] RECIP_TAB [32] = '{
        19'd262144, 19'd262144, 19'd131072, 19'd87382,
        19'd65536,  19'd52429,  19'd43691,  19'd37450,
        19'd32768,  19'd29128,  19'd26215,  19'd23832,
        19'd21846,  19'd20165,  19'd18725,  19'd17477,
        19'd16384,  19'd15421,  19'd14564,  19'd13798,
        19'd13108,  19'd12484,  19'd11916,  19'd11398,
        19'd10923,  19'd10486,  19'd10083,  19'd9710,
        19'd9363,   19'd9040,   19'd8739,   19'd8457
    };

endpackage

// ----- src/nearest_neighbor_image_scaler.sv -----
// Nearest neighbor image scaler top level: frame store and fetch address pipeline.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per clock sustained while the output is not stalled. A fetch
// result passes four register stages, the first loaded by the accept itself:
// S1 input register, S2 coordinate multiply, S3 shift/clamp/remainder check,
// S4 frame store read (single port, one access per cycle, read data registered).
// Loads write the store at the S3 -> S4 step, so a later fetch always sees them.
// Reset (synchronous, active low) clears valid bits and config registers only;
// the frame store is not cleared. Each stage advances when the one ahead is
// empty or advancing, so bubbles collapse and o_in_stall rises only when all
// four stages hold items and the output is stalled.
module nearest_neighbor_image_scaler #(
    parameter int MAX_ROWS        = nnis_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS        = nnis_pkg::MAX_COLS_DEF,
    parameter int SCALE_FRAC_BITS = nnis_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nnis_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nnis_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnis_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int CW_  = nnis_pkg::COORD_W;
    localparam int PW   = nnis_pkg::PIX_W;
    localparam int IW   = nnis_pkg::INV_W;
    localparam int FW   = nnis_pkg::FACT_W;
    localparam int SW   = nnis_pkg::SIZE_W;
    localparam int PRW  = CW_ + IW;                        // product width
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMW = CW_ + 1;                         // holds 4096

    // ---------------- configuration registers ----------------
    logic            r_mode;
    logic [IW-1:0]   r_inv_scale;
    logic [FW-1:0]   r_int_factor;
    logic [SW-1:0]   r_src_rows;
    logic [SW-1:0]   r_src_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= nnis_pkg::MODE_SCALE;
            r_inv_scale  <= IW'(65536);
            r_int_factor <= FW'(2);
            r_src_rows   <= SW'(256);
            r_src_cols   <= SW'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (nnis_pkg::t_cfg_idx'(i_cfg_index))
                nnis_pkg::CFG_MODE:       r_mode       <= i_cfg_data[0];
                nnis_pkg::CFG_INV_SCALE:  r_inv_scale  <= i_cfg_data[IW-1:0];
                nnis_pkg::CFG_INT_FACTOR: r_int_factor <= i_cfg_data[FW-1:0];
                nnis_pkg::CFG_SRC_ROWS:   r_src_rows   <= i_cfg_data[SW-1:0];
                nnis_pkg::CFG_SRC_COLS:   r_src_cols   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Derived config: effective factor, reciprocal, clamp limits.
    logic                            mark;
    logic [FW-1:0]                   f_eff;
    logic [nnis_pkg::RECIP_W-1:0]    recip;
    logic [LIMW-1:0]                 rows_eff;
    logic [LIMW-1:0]                 cols_eff;
    logic [RW-1:0]                   row_top;
    logic [CLW-1:0]                  col_top;

    always_comb begin
        mark  = (r_mode == nnis_pkg::MODE_MARK);
        f_eff = (r_int_factor == '0) ? FW'(1) : r_int_factor;
        recip = nnis_pkg::RECIP_TAB[r_int_factor];
        if (r_src_rows == '0)
            rows_eff = LIMW'(1);
        else if (LIMW'(r_src_rows) > LIMW'(MAX_ROWS))
            rows_eff = LIMW'(MAX_ROWS);
        else
            rows_eff = LIMW'(r_src_rows);
        if (r_src_cols == '0)
            cols_eff = LIMW'(1);
        else if (LIMW'(r_src_cols) > LIMW'(MAX_COLS))
            cols_eff = LIMW'(MAX_COLS);
        else
            cols_eff = LIMW'(r_src_cols);
        row_top = RW'(rows_eff - LIMW'(1));
        col_top = CLW'(cols_eff - LIMW'(1));
    end

    // ---------------- pipeline flow control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    // ---------------- S1: input register ----------------
    logic             r_op1;
    logic [CW_-1:0]   r_row1;
    logic [CW_-1:0]   r_col1;
    logic [PW-1:0]    r_pix1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (en1)
            r_v1 <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_op1  <= i_in_data.operation;
            r_row1 <= i_in_data.row;
            r_col1 <= i_in_data.col;
            r_pix1 <= i_in_data.pixel_in;
        end
    end

    // ---------------- S2: coordinate times inverse scale (or reciprocal) ----------------
    logic [IW-1:0]    mul_k;
    logic             r_op2;
    logic [CW_-1:0]   r_row2;
    logic [CW_-1:0]   r_col2;
    logic [PW-1:0]    r_pix2;
    logic [PRW-1:0]   r_prod_r2;
    logic [PRW-1:0]   r_prod_c2;

    assign mul_k = mark ? IW'(recip) : r_inv_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v2 <= 1'b0;
        else if (en2)
            r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_op2     <= r_op1;
            r_row2    <= r_row1;
            r_col2    <= r_col1;
            r_pix2    <= r_pix1;
            r_prod_r2 <= PRW'(r_row1) * PRW'(mul_k);
            r_prod_c2 <= PRW'(r_col1) * PRW'(mul_k);
        end
    end

    // ---------------- S3: shift, clamp, multiple-of-factor check ----------------
    logic [PRW-1:0]     q_r;
    logic [PRW-1:0]     q_c;
    logic [CW_+FW-1:0]  back_r;
    logic [CW_+FW-1:0]  back_c;
    logic               on_grid;
    logic               load_ok;
    logic [RW-1:0]      n_sr;
    logic [CLW-1:0]     n_sc;
    logic               n_ins;

    always_comb begin
        q_r     = mark ? (r_prod_r2 >> nnis_pkg::RECIP_SHIFT) : (r_prod_r2 >> SCALE_FRAC_BITS);
        q_c     = mark ? (r_prod_c2 >> nnis_pkg::RECIP_SHIFT) : (r_prod_c2 >> SCALE_FRAC_BITS);
        // quotient times factor gives the coordinate back only on exact multiples
        back_r  = (CW_+FW)'(q_r[CW_-1:0]) * (CW_+FW)'(f_eff);
        back_c  = (CW_+FW)'(q_c[CW_-1:0]) * (CW_+FW)'(f_eff);
        on_grid = (back_r == (CW_+FW)'(r_row2)) && (back_c == (CW_+FW)'(r_col2));
        load_ok = (LIMW'(r_row2) < LIMW'(MAX_ROWS)) && (LIMW'(r_col2) < LIMW'(MAX_COLS));
        n_ins   = 1'b0;
        if (r_op2 == nnis_pkg::OP_LOAD) begin
            n_sr = RW'(r_row2);
            n_sc = CLW'(r_col2);
        end else begin
            n_sr  = (q_r > PRW'(row_top)) ? row_top : RW'(q_r);
            n_sc  = (q_c > PRW'(col_top)) ? col_top : CLW'(q_c);
            n_ins = mark && !on_grid;
        end
    end

    logic             r_op3;
    logic             r_ok3;
    logic             r_ins3;
    logic [RW-1:0]    r_sr3;
    logic [CLW-1:0]   r_sc3;
    logic [PW-1:0]    r_pix3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v3 <= 1'b0;
        else if (en3)
            r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_op3  <= r_op2;
            r_ok3  <= load_ok;
            r_ins3 <= n_ins;
            r_sr3  <= n_sr;
            r_sc3  <= n_sc;
            r_pix3 <= r_pix2;
        end
    end

    // ---------------- S4: frame store access ----------------
    logic [PW-1:0]  r_frame [DEPTH];
    logic [AW-1:0]  addr;
    logic [PW-1:0]  r_rd;
    logic           r_ins4;

    assign addr = AW'(r_sr3) * AW'(MAX_COLS) + AW'(r_sc3);

    // single port: a load writes, a fetch reads, one per cycle
    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            if (r_op3 == nnis_pkg::OP_LOAD) begin
                if (r_ok3)
                    r_frame[addr] <= r_pix3;
            end else begin
                r_rd <= r_frame[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v4 <= 1'b0;
        else if (en4)
            r_v4 <= r_v3 && (r_op3 == nnis_pkg::OP_FETCH);
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3)
            r_ins4 <= r_ins3;
    end

    // inserted pixels carry zero gray
    assign o_out_valid          = r_v4;
    assign o_out_data.pixel_out = r_ins4 ? '0 : r_rd;
    assign o_out_data.inserted  = r_ins4;

endmodule

// ----- verif/nnis_checker.sv -----
`timescale 1ns / 1ps
// Scaler checker: watches all channels, predicts fetch results and compares them.
module nnis_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  nnis_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  nnis_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnis_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_pending_results,
    output int                             o_mismatch_count
);

    localparam int MAX_ROWS_DEF        = nnis_pkg::MAX_ROWS_DEF;
    localparam int MAX_COLS_DEF        = nnis_pkg::MAX_COLS_DEF;
    localparam int SCALE_FRAC_BITS_DEF = nnis_pkg::SCALE_FRAC_BITS_DEF;
    localparam int PIX_W               = nnis_pkg::PIX_W;
    localparam int COORD_W             = nnis_pkg::COORD_W;
    localparam int INV_W               = nnis_pkg::INV_W;
    localparam int FACT_W              = nnis_pkg::FACT_W;
    localparam int SIZE_W              = nnis_pkg::SIZE_W;

    logic [PIX_W-1:0]    frame_copy [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
    nnis_pkg::t_mode     mode_cfg;
    logic [INV_W-1:0]    inv_cfg;
    logic [FACT_W-1:0]   factor_cfg;
    logic [SIZE_W-1:0]   rows_cfg;
    logic [SIZE_W-1:0]   cols_cfg;
    nnis_pkg::t_out_item pixel_expect [$];
    int                  mismatches = 0;

    // zero acts as one, oversize acts as the store limit
    function automatic int unsigned size_in_use(logic [SIZE_W-1:0] val, int unsigned limit);
        if (val == 0) return 1;
        if (val > limit) return limit;
        return val;
    endfunction

    function automatic int unsigned clamp_to(longint unsigned v, int unsigned size);
        return (v > size - 1) ? size - 1 : int'(v);
    endfunction

    function automatic nnis_pkg::t_out_item predict_fetch(logic [COORD_W-1:0] r,
                                                          logic [COORD_W-1:0] c);
        int unsigned         rows_eff;
        int unsigned         cols_eff;
        int unsigned         f;
        int unsigned         sr;
        int unsigned         sc;
        longint unsigned     pr;
        longint unsigned     pc;
        nnis_pkg::t_out_item res;
        rows_eff = size_in_use(rows_cfg, MAX_ROWS_DEF);
        cols_eff = size_in_use(cols_cfg, MAX_COLS_DEF);
        res = '0;
        if (mode_cfg == nnis_pkg::MODE_SCALE) begin
            pr = (64'(r) * 64'(inv_cfg)) >> SCALE_FRAC_BITS_DEF;
            pc = (64'(c) * 64'(inv_cfg)) >> SCALE_FRAC_BITS_DEF;
            sr = clamp_to(pr, rows_eff);
            sc = clamp_to(pc, cols_eff);
            res.pixel_out = frame_copy[sr * MAX_COLS_DEF + sc];
        end else begin
            f = (factor_cfg == 0) ? 1 : factor_cfg;
            if ((r % f) == 0 && (c % f) == 0) begin
                sr = clamp_to(r / f, rows_eff);
                sc = clamp_to(c / f, cols_eff);
                res.pixel_out = frame_copy[sr * MAX_COLS_DEF + sc];
            end else begin
                res.inserted = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        nnis_pkg::t_out_item want;
        if (!i_rst_n) begin
            mode_cfg   = nnis_pkg::MODE_SCALE;
            inv_cfg    = 22'd65536;
            factor_cfg = 5'd2;
            rows_cfg   = 9'd256;
            cols_cfg   = 9'd256;
            pixel_expect.delete();
        end else begin
            // results first: an item accepted on this edge cannot be answered on it
            if (i_out_valid && !i_out_stall) begin
                if (pixel_expect.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, actual pixel_out %0d inserted %0b",
                             $time, i_out_data.pixel_out, i_out_data.inserted);
                end else begin
                    want = pixel_expect.pop_front();
                    if (i_out_data.pixel_out !== want.pixel_out) begin
                        mismatches++;
                        $display("%0t: pixel_out expected %0d actual %0d", $time,
                                 want.pixel_out, i_out_data.pixel_out);
                    end
                    if (i_out_data.inserted !== want.inserted) begin
                        mismatches++;
                        $display("%0t: inserted expected %0b actual %0b", $time,
                                 want.inserted, i_out_data.inserted);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (nnis_pkg::t_cfg_idx'(i_cfg_index))
                    nnis_pkg::CFG_MODE:       mode_cfg   = nnis_pkg::t_mode'(i_cfg_data[0]);
                    nnis_pkg::CFG_INV_SCALE:  inv_cfg    = i_cfg_data[INV_W-1:0];
                    nnis_pkg::CFG_INT_FACTOR: factor_cfg = i_cfg_data[FACT_W-1:0];
                    nnis_pkg::CFG_SRC_ROWS:   rows_cfg   = i_cfg_data[SIZE_W-1:0];
                    nnis_pkg::CFG_SRC_COLS:   cols_cfg   = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.operation == nnis_pkg::OP_LOAD) begin
                    if (i_in_data.row < MAX_ROWS_DEF && i_in_data.col < MAX_COLS_DEF)
                        frame_copy[i_in_data.row * MAX_COLS_DEF + i_in_data.col] =
                            i_in_data.pixel_in;
                end else begin
                    pixel_expect.push_back(predict_fetch(i_in_data.row, i_in_data.col));
                end
            end
        end
        o_pending_results <= pixel_expect.size();
        o_mismatch_count  <= mismatches;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Scaler testbench top: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;

    localparam int MAX_ROWS_DEF        = nnis_pkg::MAX_ROWS_DEF;
    localparam int MAX_COLS_DEF        = nnis_pkg::MAX_COLS_DEF;
    localparam int SCALE_FRAC_BITS_DEF = nnis_pkg::SCALE_FRAC_BITS_DEF;
    localparam int COORD_W             = nnis_pkg::COORD_W;
    localparam int PIX_W               = nnis_pkg::PIX_W;
    localparam int INV_W               = nnis_pkg::INV_W;
    localparam int FACT_W              = nnis_pkg::FACT_W;
    localparam int SIZE_W              = nnis_pkg::SIZE_W;
    localparam int CFG_IDX_W           = nnis_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W           = nnis_pkg::CFG_DAT_W;

    // cycles allowed after the last result for loads still in the pipe
    localparam int SETTLE_CYCLES = 32;
    // long output hold, long enough to fill all four stages and stall the input
    localparam int LONG_HOLD = 300;
    localparam nnis_pkg::t_cfg_idx REG_ORDER [5] = '{
        nnis_pkg::CFG_MODE, nnis_pkg::CFG_INV_SCALE, nnis_pkg::CFG_INT_FACTOR,
        nnis_pkg::CFG_SRC_ROWS, nnis_pkg::CFG_SRC_COLS};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    nnis_pkg::t_in_item   in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    nnis_pkg::t_out_item  out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int pending_results;
    int mismatch_count;

    // stimulus-side bookkeeping: which store entries hold a loaded pixel
    bit loaded_px [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    always #5 clk = ~clk;

    nearest_neighbor_image_scaler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nnis_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_data         (in_item),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_data        (out_item),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending_results (pending_results),
        .o_mismatch_count  (mismatch_count)
    );

    // Present one item, optionally after a random idle burst, and return on the
    // edge that accepts it. Valid stays high so back-to-back items need no bubble.
    task automatic send_item(input nnis_pkg::t_op op, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] c, input logic [PIX_W-1:0] px);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op, r, c, px};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_pixel(input int unsigned r, input int unsigned c,
                              input logic [PIX_W-1:0] px);
        // loads outside the store are dropped by the block, so they load nothing
        if (r < MAX_ROWS_DEF && c < MAX_COLS_DEF)
            loaded_px[r * MAX_COLS_DEF + c] = 1'b1;
        send_item(nnis_pkg::OP_LOAD, COORD_W'(r), COORD_W'(c), px);
    endtask

    task automatic fetch_pixel(input int unsigned r, input int unsigned c);
        // pixel_in is don't-care on a fetch; keep it random to prove that
        send_item(nnis_pkg::OP_FETCH, COORD_W'(r), COORD_W'(c),
                  PIX_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every fetch has been answered. The first edge
    // lets the checker's pending count catch up with the last accepted item.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Destination coordinate: mostly inside the interesting destination span,
    // snapped to the mark grid most of the time, plus full-range and corner picks.
    function automatic int unsigned pick_dest(longint unsigned span, int unsigned step);
        int unsigned v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 4095);
            1:       v = $urandom_range(0, 1) ? 4095 : 0;
            default: begin
                v = $urandom_range(0, int'(span) - 1);
                if (step > 1 && $urandom_range(0, 3) != 0)
                    v = (v / step) * step;
            end
        endcase
        return v;
    endfunction

    // One configuration phase: wait for idle, write all five registers, make sure
    // the source region is loaded (so no fetch can read an unwritten entry), then
    // run a random mix of fetches, in-store loads and loads that miss the store.
    task automatic run_phase(input nnis_pkg::t_mode md, input logic [INV_W-1:0] inv,
                             input logic [FACT_W-1:0] fac, input logic [SIZE_W-1:0] rows,
                             input logic [SIZE_W-1:0] cols, input int n_random,
                             input bit idle, input bit long_hold);
        logic [CFG_DAT_W-1:0] vals [5];
        int unsigned          rows_eff;
        int unsigned          cols_eff;
        int unsigned          step;
        int unsigned          kind;
        longint unsigned      row_span;
        longint unsigned      col_span;
        drain(SETTLE_CYCLES);
        tx_idle_en = idle;
        rx_idle_en <= idle;

        vals[0] = CFG_DAT_W'(md);
        vals[1] = inv;
        vals[2] = CFG_DAT_W'(fac);
        vals[3] = CFG_DAT_W'(rows);
        vals[4] = CFG_DAT_W'(cols);
        for (int k = 0; k < 5; k++) begin
            cfg_index <= REG_ORDER[k];
            cfg_data  <= vals[k];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;

        rows_eff = (rows == 0) ? 1 : (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
        cols_eff = (cols == 0) ? 1 : (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
        for (int r = 0; r < rows_eff; r++)
            for (int c = 0; c < cols_eff; c++)
                if (!loaded_px[r * MAX_COLS_DEF + c])
                    load_pixel(r, c, PIX_W'($urandom_range(0, 255)));

        // span of destination coordinates that map inside the source frame
        if (md == nnis_pkg::MODE_SCALE) begin
            step = 1;
            row_span = (inv == 0) ? 4096 : ((64'(rows_eff) << SCALE_FRAC_BITS_DEF) / inv) + 2;
            col_span = (inv == 0) ? 4096 : ((64'(cols_eff) << SCALE_FRAC_BITS_DEF) / inv) + 2;
        end else begin
            step = (fac == 0) ? 1 : fac;
            row_span = rows_eff * step + step;
            col_span = cols_eff * step + step;
        end
        if (row_span > 4096) row_span = 4096;
        if (col_span > 4096) col_span = 4096;

        if (long_hold)
            hold_req <= 1'b1;
        for (int i = 0; i < n_random; i++) begin
            // sender pause until the pipe is empty, mid-phase
            if (i == n_random / 2)
                drain(0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                if ($urandom_range(0, 1))
                    load_pixel($urandom_range(MAX_ROWS_DEF, 4095), $urandom_range(0, 4095),
                               PIX_W'($urandom_range(0, 255)));
                else
                    load_pixel($urandom_range(0, 4095), $urandom_range(MAX_COLS_DEF, 4095),
                               PIX_W'($urandom_range(0, 255)));
            end else if (kind <= 2) begin
                load_pixel($urandom_range(0, MAX_ROWS_DEF - 1), $urandom_range(0, MAX_COLS_DEF - 1),
                           PIX_W'($urandom_range(0, 255)));
            end else begin
                fetch_pixel(pick_dest(row_span, step), pick_dest(col_span, step));
            end
        end
    endtask

    // Output side: random stall bursts, plus one long hold on request so the
    // block backs up and stalls its input while the sender keeps offering items.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_done <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, under reset settings (scale mode, unity inverse scale, 256x256):
        // corner pixels with extreme values, loads past the store edge that must
        // not alias onto row or column zero, and far fetches that clamp to the edge.
        load_pixel(0, 0, 8'hFF);
        load_pixel(255, 255, 8'h00);
        load_pixel(0, 255, 8'hA5);
        load_pixel(255, 0, 8'h5A);
        load_pixel(256, 0, 8'h00);
        load_pixel(0, 256, 8'h11);
        load_pixel(4095, 4095, 8'h22);
        fetch_pixel(0, 0);
        fetch_pixel(255, 255);
        fetch_pixel(4095, 4095);
        fetch_pixel(0, 4095);
        fetch_pixel(4095, 0);
        fetch_pixel(255, 0);
        send_item(nnis_pkg::OP_FETCH, 12'd0, 12'd255, 8'hFF);

        // scale mode: upscale, max and min inverse scale, zero inverse scale,
        // zero and oversize source sizes
        run_phase(nnis_pkg::MODE_SCALE, 22'd32768,   5'd2,  9'd12,  9'd10,  100, 1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_SCALE, 22'd4194303, 5'd1,  9'd256, 9'd0,   60,  1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_SCALE, 22'd1,       5'd16, 9'd1,   9'd256, 60,  1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_SCALE, 22'd0,       5'd17, 9'd511, 9'd1,   40,  1'b1, 1'b0);
        // mark mode: factor two on a one-row frame, then the long receiver hold,
        // factor zero (acts as one), factor sixteen, and the top factor, thirty-one
        run_phase(nnis_pkg::MODE_MARK,  22'd65536,   5'd2,  9'd0,   9'd511, 60,  1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_MARK,  22'd87381,   5'd2,  9'd8,   9'd8,   150, 1'b1, 1'b1);
        run_phase(nnis_pkg::MODE_MARK,  22'd65536,   5'd0,  9'd6,   9'd7,   70,  1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_MARK,  22'd65536,   5'd16, 9'd4,   9'd4,   70,  1'b1, 1'b0);
        run_phase(nnis_pkg::MODE_MARK,  22'd65536,   5'd31, 9'd3,   9'd5,   40,  1'b1, 1'b0);
        // random settings
        run_phase(nnis_pkg::t_mode'($urandom_range(0, 1)), INV_W'($urandom_range(8192, 262144)),
                  FACT_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)),
                  SIZE_W'($urandom_range(1, 16)), 100, 1'b1, 1'b0);
        // closing stretch at full rate, no idling on either side
        run_phase(nnis_pkg::MODE_SCALE, 22'd45000,   5'd1,  9'd10,  9'd10,  120, 1'b0, 1'b0);

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/nnis_pkg.sv
src/nearest_neighbor_image_scaler.sv
verif/nnis_checker.sv
verif/testbench.sv
